// ===== design/dws_pkg.sv =====
// Shared types and constants for the double-ended queue with search.
`default_nettype none
package dws_pkg;
	localparam int DEPTH   = 64;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DATA_W  = 32;
	localparam int REQ_W   = 3;
	localparam int COUNT_W = 7;

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH_FRONT = 3'd0,
		REQ_PUSH_BACK  = 3'd1,
		REQ_POP_FRONT  = 3'd2,
		REQ_POP_BACK   = 3'd3,
		REQ_PEEK_FRONT = 3'd4,
		REQ_SEARCH     = 3'd5,
		REQ_CLEAR      = 3'd6
	} req_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_SHR,
		CELL_SHL,
		CELL_APPEND,
		CELL_DROP_TAIL,
		CELL_CLEAR
	} cell_op_t;

	typedef struct packed {
		cell_op_t                 op;
		logic signed [DATA_W-1:0] word;
	} cell_ctl_t;
endpackage
`default_nettype wire

// ===== design/dws_req_if.sv =====
// Request channel: request code and value or search key.
`default_nettype none
interface dws_req_if;
	logic                              valid;
	logic                              ready;
	logic [dws_pkg::REQ_W-1:0]         req_type;
	logic signed [dws_pkg::DATA_W-1:0] value_in;

	modport source(output valid, output req_type, output value_in, input ready);
	modport sink(input valid, input req_type, input value_in, output ready);
endinterface
`default_nettype wire

// ===== design/dws_rsp_if.sv =====
// Response channel: value, found flag, status and entry count.
`default_nettype none
interface dws_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [dws_pkg::DATA_W-1:0]  value_out;
	logic                               found;
	logic [1:0]                         status;
	logic [dws_pkg::COUNT_W-1:0]        count;

	modport source(output valid, output value_out, output found, output status,
		output count, input ready);
	modport sink(input valid, input value_out, input found, input status,
		input count, output ready);
endinterface
`default_nettype wire

// ===== design/dws_cell.sv =====
// One queue cell: a stored word, its occupancy flag, key compare and tail tap.
`default_nettype none
module dws_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dws_pkg::cell_ctl_t                ctl,
	input  logic signed [dws_pkg::DATA_W-1:0] prev_data,
	input  logic                              prev_occ,
	input  logic signed [dws_pkg::DATA_W-1:0] next_data,
	input  logic                              next_occ,
	output logic signed [dws_pkg::DATA_W-1:0] data,
	output logic                              occ,
	output logic                              hit,
	output logic [dws_pkg::DATA_W-1:0]        tail_data
);
	import dws_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic                     occ_q;
	logic                     is_tail;

	assign is_tail   = occ_q && !next_occ;
	assign data      = data_q;
	assign occ       = occ_q;
	assign hit       = occ_q && (data_q == ctl.word);
	assign tail_data = is_tail ? data_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			case (ctl.op)
				CELL_SHR:       occ_q <= prev_occ;
				CELL_SHL:       occ_q <= next_occ;
				CELL_APPEND:    if (!occ_q && prev_occ) occ_q <= 1'b1;
				CELL_DROP_TAIL: if (is_tail) occ_q <= 1'b0;
				CELL_CLEAR:     occ_q <= 1'b0;
				default:        occ_q <= occ_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_SHR:    data_q <= prev_data;
			CELL_SHL:    data_q <= next_data;
			CELL_APPEND: if (!occ_q && prev_occ) data_q <= ctl.word;
			default:     data_q <= data_q;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit words with parallel key search.
// The queue is a row of DEPTH cells with the front word always in cell 0: a push
// at the front shifts the row one cell back, a pop at the front shifts it forward,
// and the back is the last occupied cell. One request is taken every cycle while
// the response register is free or being emptied; its response appears on the
// next cycle. Every request, a search of all cells included, finishes in the same
// cycle in which the cell row updates. A push to a full queue is dropped with
// status full; a pop or peek of an empty queue returns -1 with status empty.
`default_nettype none
module deque_with_search (
	input  logic  clk,
	input  logic  arst_n,
	dws_req_if.sink   req,
	dws_rsp_if.source rsp
);
	import dws_pkg::*;

	logic signed [DATA_W-1:0] data_w      [DEPTH];
	logic                     occ_w       [DEPTH];
	logic signed [DATA_W-1:0] prev_data_w [DEPTH];
	logic                     prev_occ_w  [DEPTH];
	logic signed [DATA_W-1:0] next_data_w [DEPTH];
	logic                     next_occ_w  [DEPTH];
	logic [DATA_W-1:0]        tail_w      [DEPTH];
	logic [DEPTH-1:0]         hit_vec;
	logic [DEPTH-1:0]         occ_vec;

	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         count_nxt;
	logic                     rsp_valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     found_q;
	status_t                  status_q;

	logic                     accept;
	logic                     empty;
	logic                     full;
	logic [DATA_W-1:0]        tail_or;
	cell_op_t                 op;
	cell_ctl_t                ctl;
	status_t                  status_nxt;
	logic signed [DATA_W-1:0] value_nxt;
	logic                     found_nxt;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(DEPTH));

	always_comb begin
		tail_or = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_or = tail_or | tail_w[i];
			occ_vec[i] = occ_w[i];
		end
	end

	always_comb begin
		op         = CELL_HOLD;
		status_nxt = ST_OK;
		value_nxt  = '0;
		found_nxt  = 1'b0;
		count_nxt  = count_q;
		unique case (req_t'(req.req_type)) inside
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					op        = (req_t'(req.req_type) == REQ_PUSH_FRONT) ?
						CELL_SHR : CELL_APPEND;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
					value_nxt  = '1;
				end else begin
					if (req_t'(req.req_type) == REQ_POP_FRONT) begin
						op        = CELL_SHL;
						value_nxt = data_w[0];
					end else begin
						op        = CELL_DROP_TAIL;
						value_nxt = signed'(tail_or);
					end
					count_nxt = count_q - CNT_W'(1);
				end
			end
			REQ_PEEK_FRONT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
					value_nxt  = '1;
				end else begin
					value_nxt = data_w[0];
				end
			end
			REQ_SEARCH: begin
				found_nxt = |hit_vec;
			end
			REQ_CLEAR: begin
				op        = CELL_CLEAR;
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	assign ctl.op   = accept ? op : CELL_HOLD;
	assign ctl.word = req.value_in;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign prev_data_w[i] = req.value_in;
			assign prev_occ_w[i]  = 1'b1;
		end else begin : g_body
			assign prev_data_w[i] = data_w[i-1];
			assign prev_occ_w[i]  = occ_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next_data_w[i] = data_w[i];
			assign next_occ_w[i]  = 1'b0;
		end else begin : g_inner
			assign next_data_w[i] = data_w[i+1];
			assign next_occ_w[i]  = occ_w[i+1];
		end

		dws_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_data (prev_data_w[i]),
			.prev_occ  (prev_occ_w[i]),
			.next_data (next_data_w[i]),
			.next_occ  (next_occ_w[i]),
			.data      (data_w[i]),
			.occ       (occ_w[i]),
			.hit       (hit_vec[i]),
			.tail_data (tail_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q  <= value_nxt;
			found_q  <= found_nxt;
			status_q <= status_nxt;
		end
	end

	// count_q only moves on acceptance, which also drains the held word
	assign rsp.valid     = rsp_valid_q;
	assign rsp.value_out = value_q;
	assign rsp.found     = found_q;
	assign rsp.status    = status_q;
	assign rsp.count     = COUNT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	a_occ_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == int'(count_q))
		else $error("occupied cells disagree with entry count");

	a_occ_packed: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, occ_vec} + {{DEPTH{1'b0}}, 1'b1}))
		else $error("occupied cells not contiguous from the front");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == ST_EMPTY |-> value_q == '1 && !found_q)
		else $error("empty status without all-ones value");
endmodule
`default_nettype wire
